### src/bdhd_pkg.sv
// ----------------------------------------------------------------------------
// bdhd_pkg
// Types and register indexes shared by the button debounce / hold detector.
// ----------------------------------------------------------------------------
package bdhd_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PULLUP_MODE  = 3'd0,
    REG_HOLD_THRESH  = 3'd1,
    REG_DEBOUNCE     = 3'd2,
    REG_EVENT_ENABLE = 3'd3,
    REG_EVENT_MASK   = 3'd4
  } cfg_reg_t;

  localparam logic [31:0] HOLD_THRESH_RST = 32'd1000;
  localparam logic [30:0] DEBOUNCE_RST    = 31'd50;

  // event mask bit positions
  localparam int unsigned EV_PRESS   = 0;
  localparam int unsigned EV_HOLD    = 1;
  localparam int unsigned EV_DOWN    = 2;
  localparam int unsigned EV_RELEASE = 3;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
    logic        clear_pushed;
    logic        clear_hold;
    logic        clear_release;
  } sample_t;

  typedef struct packed {
    logic pressed_now;
    logic pushed_seen;
    logic hold_seen;
    logic release_seen;
    logic fire_on_press;
    logic fire_on_hold;
    logic fire_while_down;
    logic fire_on_release;
  } result_t;

endpackage

### src/button_debounce_hold_detector_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_detector_unit
// Debounces a sampled button pin and flags push, hold and release events.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pin sample per transfer (level, wrapping ms stamp, clear
//           requests). A transfer happens when in_valid is high and in_stall
//           is low.
//   out_* : one result per sample, in order: debounced state, sticky flags as
//           seen before the requested clears, and masked event bits.
//   cfg_* : plain write port, one register per cycle while cfg_we is high.
//           Write only while no sample is in flight.
// Timing: a sample is captured in an input register, processed in a single
//   pass against the button state, and its result is written to the output
//   register once that register is free, which out_stall can hold back.
//   One sample per cycle is taken in steady state while out_stall is low; the
//   limit is the single state update per cycle.
// Stall: while out_stall holds the result, the input register still fills;
//   once both registers are full in_stall rises, and nothing is lost.
// Reset (rst_n low, synchronous): both stages empty, button state and flags
//   cleared, registers at their defaults.
// ----------------------------------------------------------------------------
module button_debounce_hold_detector_unit
  import bdhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic        pullup_r;
  logic [31:0] hold_thr_r;
  logic [30:0] debounce_r;
  logic        ev_en_r;
  logic [3:0]  ev_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pullup_r   <= 1'b0;
      hold_thr_r <= HOLD_THRESH_RST;
      debounce_r <= DEBOUNCE_RST;
      ev_en_r    <= 1'b0;
      ev_mask_r  <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PULLUP_MODE:  pullup_r   <= cfg_wdata[0];
        REG_HOLD_THRESH:  hold_thr_r <= cfg_wdata;
        REG_DEBOUNCE:     debounce_r <= cfg_wdata[30:0];
        REG_EVENT_ENABLE: ev_en_r    <= cfg_wdata[0];
        REG_EVENT_MASK:   ev_mask_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic    s1_valid_r;
  sample_t s1_data_r;
  logic    s1_adv;
  logic    out_free;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // button state
  logic        pressed_r, push_r, release_r, holding_r;
  logic [31:0] press_stamp_r, release_stamp_r;
  logic        pressed_nxt, push_nxt, release_nxt, holding_nxt;
  logic [31:0] press_stamp_nxt, release_stamp_nxt;
  result_t     res_nxt;

  logic        pin_down;
  logic [31:0] now;
  logic [31:0] d_press, d_rel, d_hold;
  logic        db_press_ok, db_rel_ok;
  logic        press_acc, rel_acc, hold_now;
  logic [31:0] ps_upd;
  logic        push_upd, holding_upd, release_upd, pressed_upd;
  logic [3:0]  ev;

  always_comb begin
    now      = s1_data_r.now_ms;
    pin_down = s1_data_r.pin_level != pullup_r;
    ev       = ev_en_r ? ev_mask_r : 4'd0;

    // a zero stamp means no stamp held: the edge passes unchecked
    d_press     = now - press_stamp_r;
    d_rel       = now - release_stamp_r;
    db_press_ok = (press_stamp_r == 32'd0) ||
                  (!d_press[31] && (d_press[30:0] > debounce_r));
    db_rel_ok   = (release_stamp_r == 32'd0) ||
                  (!d_rel[31] && (d_rel[30:0] > debounce_r));

    press_acc = pin_down && !pressed_r && db_press_ok;
    rel_acc   = !pin_down && pressed_r && db_rel_ok;

    ps_upd   = press_acc ? now : press_stamp_r;
    d_hold   = now - ps_upd;
    hold_now = pin_down && !holding_r && (d_hold > hold_thr_r);

    pressed_upd = press_acc ? 1'b1 : (rel_acc ? 1'b0 : pressed_r);
    push_upd    = push_r | press_acc;
    release_upd = release_r | rel_acc;
    holding_upd = rel_acc ? 1'b0 : (holding_r | hold_now);

    res_nxt.pressed_now     = pressed_upd;
    res_nxt.pushed_seen     = push_upd;
    res_nxt.hold_seen       = holding_upd;
    res_nxt.release_seen    = release_upd;
    res_nxt.fire_on_press   = press_acc & ev[EV_PRESS];
    res_nxt.fire_on_hold    = hold_now & ev[EV_HOLD];
    res_nxt.fire_while_down = pin_down & ev[EV_DOWN];
    res_nxt.fire_on_release = rel_acc & ev[EV_RELEASE];

    // clears act after the flags have been reported
    pressed_nxt       = pressed_upd;
    push_nxt          = push_upd & !s1_data_r.clear_pushed;
    release_nxt       = release_upd & !s1_data_r.clear_release;
    release_stamp_nxt = press_acc ? 32'd0 : (rel_acc ? now : release_stamp_r);
    press_stamp_nxt   = rel_acc ? now : ps_upd;
    holding_nxt       = holding_upd;
    if (s1_data_r.clear_hold && holding_upd) begin
      press_stamp_nxt = now;   // restart hold timing so holds repeat
      holding_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r       <= 1'b0;
      push_r          <= 1'b0;
      release_r       <= 1'b0;
      holding_r       <= 1'b0;
      press_stamp_r   <= 32'd0;
      release_stamp_r <= 32'd0;
    end else if (s1_adv) begin
      pressed_r       <= pressed_nxt;
      push_r          <= push_nxt;
      release_r       <= release_nxt;
      holding_r       <= holding_nxt;
      press_stamp_r   <= press_stamp_nxt;
      release_stamp_r <= release_stamp_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= res_nxt;
    end
  end

  // checks
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_press_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fire_on_press |-> out_data.pressed_now && out_data.pushed_seen)
    else $error("press event without pressed state");

  a_release_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fire_on_release |-> !out_data.pressed_now && out_data.release_seen)
    else $error("release event while still pressed");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fire_on_hold |-> out_data.hold_seen)
    else $error("hold event without hold flag");

  a_no_state_change_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(pressed_r) && $stable(press_stamp_r))
    else $error("button state moved without a sample");

endmodule
